/* rtl/ucbl_pkg.sv */
// ============================================================================
// ucbl_pkg - shared types and constants of the serial command loader
// Mode codes, character codes, the result record and byte insertion helper.
// ============================================================================
package ucbl_pkg;

    // Character codes
    localparam logic [7:0] CHAR_CR   = 8'd13;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_R    = 8'h52;
    localparam logic [7:0] PREV_INIT = 8'hFF;

    // Progress mark every PROGRESS_INTERVAL written bytes
    localparam int unsigned PROGRESS_INTERVAL = 8192;
    localparam int unsigned PROG_W            = $clog2(PROGRESS_INTERVAL + 1);

    typedef enum logic [2:0] {
        MODE_CMD   = 3'd0,
        MODE_LADDR = 3'd1,
        MODE_LLEN  = 3'd2,
        MODE_LDATA = 3'd3,
        MODE_RADDR = 3'd4,
        MODE_HALT  = 3'd5
    } t_mode;

    // One result transaction
    typedef struct packed {
        logic        jump_valid;
        logic [31:0] jump_address;
        logic        length_valid;
        logic [31:0] load_length;
        logic        load_done;
        logic        progress_mark;
        logic        write_valid;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic        echo_valid;
        logic [7:0]  echo_byte;
    } t_result;

    // Insert a byte into a little-endian word at byte lane idx
    function automatic logic [31:0] put_byte(input logic [31:0] word,
                                             input logic [1:0]  idx,
                                             input logic [7:0]  b);
        logic [31:0] w;
        w = word;
        case (idx)
            2'd0:    w[7:0]   = w[7:0]   | b;
            2'd1:    w[15:8]  = w[15:8]  | b;
            2'd2:    w[23:16] = w[23:16] | b;
            default: w[31:24] = w[31:24] | b;
        endcase
        return w;
    endfunction

endpackage

/* rtl/ucbl_in_stage.sv */
// ============================================================================
// ucbl_in_stage - input register of the loader
// Hold one received byte until the core consumes it.
// ============================================================================
module ucbl_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Free when empty or when the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

/* rtl/ucbl_core.sv */
// ============================================================================
// ucbl_core - command decoder and load sequencer
// Update mode and header/counter state and form one result per byte.
// ============================================================================
module ucbl_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    output ucbl_pkg::t_result    o_result
);

    localparam int unsigned PW = ucbl_pkg::PROG_W;

    ucbl_pkg::t_mode r_mode, n_mode;
    logic [1:0]      r_idx, n_idx;
    logic [7:0]      r_prev, n_prev;
    logic [31:0]     r_target, n_target;
    logic [31:0]     r_length, n_length;
    logic [31:0]     r_written, n_written;
    logic [PW-1:0]   r_prog, n_prog;

    logic [31:0]     hdr_target;
    logic [31:0]     hdr_length;
    logic [31:0]     written_inc;

    assign hdr_target  = ucbl_pkg::put_byte(r_target, r_idx, i_byte);
    assign hdr_length  = ucbl_pkg::put_byte(r_length, r_idx, i_byte);
    assign written_inc = r_written + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ucbl_pkg::MODE_CMD;
            r_idx     <= 2'd0;
            r_prev    <= ucbl_pkg::PREV_INIT;
            r_target  <= 32'd0;
            r_length  <= 32'd0;
            r_written <= 32'd0;
            r_prog    <= '0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_idx     <= n_idx;
            r_prev    <= n_prev;
            r_target  <= n_target;
            r_length  <= n_length;
            r_written <= n_written;
            r_prog    <= n_prog;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_idx     = r_idx;
        n_prev    = r_prev;
        n_target  = r_target;
        n_length  = r_length;
        n_written = r_written;
        n_prog    = r_prog;
        o_result  = '0;

        unique case (r_mode)
            ucbl_pkg::MODE_CMD: begin
                o_result.echo_valid = 1'b1;
                o_result.echo_byte  = i_byte;
                if (i_byte == ucbl_pkg::CHAR_CR) begin
                    if (r_prev == ucbl_pkg::CHAR_B) begin
                        n_mode   = ucbl_pkg::MODE_LADDR;
                        n_idx    = 2'd0;
                        n_target = 32'd0;
                    end else if (r_prev == ucbl_pkg::CHAR_R) begin
                        n_mode   = ucbl_pkg::MODE_RADDR;
                        n_idx    = 2'd0;
                        n_target = 32'd0;
                    end
                end
                n_prev = i_byte;
            end
            ucbl_pkg::MODE_LADDR: begin
                n_target = hdr_target;
                n_idx    = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_length = 32'd0;
                    n_mode   = ucbl_pkg::MODE_LLEN;
                end
            end
            ucbl_pkg::MODE_LLEN: begin
                n_length = hdr_length;
                n_idx    = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_written             = 32'd0;
                    n_prog                = '0;
                    o_result.length_valid = 1'b1;
                    o_result.load_length  = hdr_length;
                    if (hdr_length == 32'd0) begin
                        o_result.load_done = 1'b1;
                        n_mode             = ucbl_pkg::MODE_CMD;
                    end else begin
                        n_mode = ucbl_pkg::MODE_LDATA;
                    end
                end
            end
            ucbl_pkg::MODE_LDATA: begin
                o_result.write_valid   = 1'b1;
                o_result.write_address = r_target + r_written;
                o_result.write_data    = i_byte;
                n_written              = written_inc;
                // Progress counter wraps at the interval
                if (r_prog == PW'(ucbl_pkg::PROGRESS_INTERVAL - 1)) begin
                    o_result.progress_mark = 1'b1;
                    n_prog                 = '0;
                end else begin
                    n_prog = r_prog + PW'(1);
                end
                if (written_inc == r_length) begin
                    o_result.load_done = 1'b1;
                    n_mode             = ucbl_pkg::MODE_CMD;
                end
            end
            ucbl_pkg::MODE_RADDR: begin
                n_target = hdr_target;
                n_idx    = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    o_result.jump_valid   = 1'b1;
                    o_result.jump_address = hdr_target;
                    n_mode                = ucbl_pkg::MODE_HALT;
                end
            end
            default: begin
                // Halted: drop every byte until reset
            end
        endcase
    end

endmodule

/* rtl/ucbl_out_stage.sv */
// ============================================================================
// ucbl_out_stage - result register of the loader
// Hold one finished result until the downstream side takes it.
// ============================================================================
module ucbl_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ucbl_pkg::t_result    i_result,
    input  logic                 i_ready,
    output logic                 o_can_load,
    output logic                 o_valid,
    output ucbl_pkg::t_result    o_result
);

    logic              r_valid;
    ucbl_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/uart_command_blob_loader.sv */
// ============================================================================
// uart_command_blob_loader - serial command loader
// Decode received bytes into echo, blob memory writes, length and jump events.
// ============================================================================
// Usage:
//   Slave stream: one received serial byte per transaction in s_axis_tdata.
//   Master stream: exactly one result transaction per accepted byte, in order.
//   Commands: 'B' then CR starts a load (4 address bytes, 4 length bytes,
//   little-endian, then length data bytes written at address plus offset);
//   'R' then CR takes 4 address bytes, issues a jump and halts the block.
//   Path: an accepted byte sits in the input register; its result is loaded
//   into the result register when that register can take it, and shows at
//   the master port from the result register.
//   Throughput: one byte per cycle while m_axis_tready stays high, set by
//   the combinational decode/update between the input and result registers.
//   Stall: when the receiver holds m_axis_tready low, the result register
//   holds its transaction, the input register fills, and s_axis_tready then
//   drops; nothing is lost or repeated.
//   Reset: synchronous, active low; returns to command mode with the
//   previous character set to 0xFF and both registers empty.
//   tlast marks the transaction on which a load finishes.
// ============================================================================
module uart_command_blob_loader (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Received byte
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] rx_byte
    // Result
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [7:0] echo_byte, [39:8] write_address, [47:40] write_data,
    // [48] progress_mark, [80:49] load_length, [112:81] jump_address, rest zero
    output logic [119:0] o_m_axis_tdata,
    // [0] echo_valid, [1] write_valid, [2] length_valid, [3] jump_valid
    output logic [3:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast    // load_done
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              out_can_load;
    logic              fire;
    ucbl_pkg::t_result core_result;
    ucbl_pkg::t_result out_result;

    // Advance the held byte whenever the result register can take its result
    assign fire = in_valid && out_can_load;

    ucbl_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    ucbl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (in_byte),
        .o_result (core_result)
    );

    ucbl_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (core_result),
        .i_ready    (i_m_axis_tready),
        .o_can_load (out_can_load),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (out_result)
    );

    // Pack the result fields onto the stream
    assign o_m_axis_tdata = {7'd0,
                             out_result.jump_address,
                             out_result.load_length,
                             out_result.progress_mark,
                             out_result.write_data,
                             out_result.write_address,
                             out_result.echo_byte};
    assign o_m_axis_tuser = {out_result.jump_valid,
                             out_result.length_valid,
                             out_result.write_valid,
                             out_result.echo_valid};
    assign o_m_axis_tlast = out_result.load_done;

endmodule
